[rtl/sskk_pkg.sv]
// ----------------------------------------------------------------------------
// sskk_pkg: shared types and constants of the smallest-k keeper
// Holds the mode codes, field widths and the structs that travel between
// the cells of the sorting row.
// ----------------------------------------------------------------------------
package sskk_pkg;

    localparam int DEFAULT_CAPACITY = 25;

    localparam int VALUE_W = 32;
    localparam int TAG_W   = 16;
    localparam int POS_W   = 5;
    localparam int MODE_W  = 2;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        logic               insert;
        logic               clear;
        logic [VALUE_W-1:0] new_value;
        logic [TAG_W-1:0]   new_tag;
    } cell_cmd_t;

    // Content and placement flag that one cell hands to its neighbor.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]   tag;
        logic               occ;
        logic               at;
    } cell_link_t;

endpackage

[rtl/sorted_smallest_k_keeper_unit.sv]
// ----------------------------------------------------------------------------
// sorted_smallest_k_keeper_unit: keeper of the smallest CAPACITY pairs
// A row of cells holds the stored (value, tag) pairs in ascending order and
// handles insert, read and clear transactions.
// ----------------------------------------------------------------------------
// Usage:
// Each item transaction carries a mode (insert, read or clear) and its
// operands; every accepted item yields exactly one result transaction.
// An insert compares the new value against all cells at once; each qualifying cell
// then takes either the new pair or its left neighbor's pair, so equal
// values stay behind older ones and the last pair falls off when full.
// A read selects one cell by position; a clear empties every cell.
// The result is registered and valid in the cycle after item acceptance, and the
// unit takes one item per cycle while no pending result is stalled.
// When the receiver stalls a pending result, item_stall rises and the
// result holds until it is taken; no item is accepted in that time.
// Reset empties the store, zeroes every cell and drops any pending result;
// the unit accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
module sorted_smallest_k_keeper_unit
    import sskk_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [MODE_W-1:0]         mode,
    input  logic signed [VALUE_W-1:0] new_value,
    input  logic [TAG_W-1:0]          new_tag,
    input  logic [POS_W-1:0]          read_position,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [POS_W-1:0]          entry_count,
    output logic                      inserted,
    output logic [POS_W-1:0]          insert_position,
    output logic [TAG_W-1:0]          read_tag,
    output logic signed [VALUE_W-1:0] read_value,
    output logic                      read_valid
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = (CW > POS_W) ? CW : POS_W;

    logic              item_accept;
    mode_t             mode_code;
    logic              do_insert;
    logic              do_read;
    logic              do_clear;
    cell_cmd_t         cmd;
    cell_link_t        links [CAPACITY+1];
    logic [CAPACITY-1:0] landing;
    logic [CAPACITY-1:0] occ_vec;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [PW-1:0]     land_pos;
    logic              ins_hit;
    logic [TAG_W-1:0]  sel_tag;
    logic [VALUE_W-1:0] sel_value;
    logic              sel_valid;
    logic [PW+POS_W-1:0] pos_pad;
    logic [CW+POS_W-1:0] cnt_pad;
    logic [RW-1:0]     rpos_cmp;
    logic [RW-1:0]     count_cmp;

    logic              result_valid_reg;
    logic [POS_W-1:0]  entry_count_reg;
    logic              inserted_reg;
    logic [POS_W-1:0]  insert_position_reg;
    logic [TAG_W-1:0]  read_tag_reg;
    logic [VALUE_W-1:0] read_value_reg;
    logic              read_valid_reg;

    // Handshake: a pending result that is stalled blocks new items.
    assign item_stall  = result_valid_reg && result_stall;
    assign item_accept = item_valid && !item_stall;

    // Mode decode.
    assign mode_code = mode_t'(mode);
    always_comb
    begin
        do_insert = 1'b0;
        do_read   = 1'b0;
        do_clear  = 1'b0;
        unique case (mode_code)
            MODE_INSERT: do_insert = item_accept;
            MODE_READ:   do_read   = item_accept;
            MODE_CLEAR:  do_clear  = item_accept;
            default:     ;
        endcase
    end

    assign cmd.insert    = do_insert;
    assign cmd.clear     = do_clear;
    assign cmd.new_value = new_value;
    assign cmd.new_tag   = new_tag;

    // The row starts with a virtual occupied slot that never qualifies.
    assign links[0].value = '0;
    assign links[0].tag   = '0;
    assign links[0].occ   = 1'b1;
    assign links[0].at    = 1'b0;

    // Cell row.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sskk_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .prev    (links[i]),
            .link    (links[i+1]),
            .landing (landing[i])
        );
        assign occ_vec[i] = links[i+1].occ;
    end

    // The pair is kept when any slot qualifies; its position is the index
    // of the single landing cell.
    assign ins_hit = links[CAPACITY].at;
    always_comb
    begin
        land_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (landing[i])
            begin
                land_pos = land_pos | PW'(i);
            end
        end
    end

    // Read selection; positions past the row match no cell and give zero.
    always_comb
    begin
        sel_tag   = '0;
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if ({{(RW-POS_W+1){1'b0}}, read_position} == (RW+1)'(i))
            begin
                sel_tag   = links[i+1].tag;
                sel_value = links[i+1].value;
            end
        end
    end

    assign rpos_cmp  = RW'(read_position);
    assign count_cmp = RW'(count_reg);
    assign sel_valid = rpos_cmp < count_cmp;

    // Stored count, saturating at the capacity.
    always_comb
    begin
        count_next = count_reg;
        if (do_clear)
        begin
            count_next = '0;
        end
        else if (do_insert && ins_hit && (count_reg < CW'(CAPACITY)))
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign pos_pad = {{POS_W{1'b0}}, land_pos};
    assign cnt_pad = {{POS_W{1'b0}}, count_next};

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            entry_count_reg     <= cnt_pad[POS_W-1:0];
            inserted_reg        <= do_insert && ins_hit;
            insert_position_reg <= (do_insert && ins_hit) ? pos_pad[POS_W-1:0] : '0;
            read_tag_reg        <= do_read ? sel_tag : '0;
            read_value_reg      <= do_read ? sel_value : '0;
            read_valid_reg      <= do_read && sel_valid;
        end
    end

    assign result_valid    = result_valid_reg;
    assign entry_count     = entry_count_reg;
    assign inserted        = inserted_reg;
    assign insert_position = insert_position_reg;
    assign read_tag        = read_tag_reg;
    assign read_value      = read_value_reg;
    assign read_valid      = read_valid_reg;

    // The occupied cells always number exactly the stored count.
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == int'(count_reg))
        else $error("occupied cells disagree with stored count");

    // Occupied cells form a prefix of the row.
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec & (occ_vec + CAPACITY'(1))) == '0))
        else $error("occupied cells do not form a prefix");

    // A clear empties the store by the next cycle.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (count_reg == '0) && (occ_vec == '0))
        else $error("clear did not empty the store");

    // A kept pair always has exactly one landing cell.
    a_landing: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |-> (ins_hit ? $onehot(landing) : (landing == '0)))
        else $error("landing cells inconsistent with insert outcome");

endmodule

[rtl/sskk_cell.sv]
// ----------------------------------------------------------------------------
// sskk_cell: one slot of the sorting row
// Holds one (value, tag) pair with an occupied flag, decides whether the new
// pair lands here or before it, and takes either the new pair or the
// content of the previous cell on an insert, and empties on a clear.
// ----------------------------------------------------------------------------
module sskk_cell
    import sskk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  cell_link_t prev,
    output cell_link_t link,
    output logic       landing
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic               occ_reg;
    logic               occ_next;
    logic               at;

    // The new pair goes at or before this slot if the slot is free or
    // holds a strictly greater value.
    assign at = !occ_reg || ($signed(value_reg) > $signed(cmd.new_value));

    // The pair lands here when this is the first slot that qualifies.
    assign landing = at && !prev.at;

    // On an insert a qualifying slot takes the neighbor's content, or the
    // new pair if it is the landing slot.
    always_comb
    begin
        value_next = value_reg;
        tag_next   = tag_reg;
        occ_next   = occ_reg;
        if (cmd.clear)
        begin
            value_next = '0;
            tag_next   = '0;
            occ_next   = 1'b0;
        end
        else if (cmd.insert && at)
        begin
            if (prev.at)
            begin
                value_next = prev.value;
                tag_next   = prev.tag;
                occ_next   = prev.occ;
            end
            else
            begin
                value_next = cmd.new_value;
                tag_next   = cmd.new_tag;
                occ_next   = 1'b1;
            end
        end
    end

    // Slot storage; free slots hold zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            tag_reg   <= '0;
            occ_reg   <= 1'b0;
        end
        else
        begin
            value_reg <= value_next;
            tag_reg   <= tag_next;
            occ_reg   <= occ_next;
        end
    end

    assign link.value = value_reg;
    assign link.tag   = tag_reg;
    assign link.occ   = occ_reg;
    assign link.at    = at;

endmodule

[test/tb_sorted_smallest_k_keeper_unit.sv]
// ----------------------------------------------------------------------------
// tb_sorted_smallest_k_keeper_unit: self-checking bench of the smallest-k keeper
// Drives insert, read, clear and unused-mode transactions into the unit and
// predicts every result with a behavioral copy of the sorted store. Results
// are compared field by field, in order. Both sides idle at random, and the
// receiver holds off once for a long stretch so that the unit backs up.
// ----------------------------------------------------------------------------
module tb_sorted_smallest_k_keeper_unit;
    import sskk_pkg::*;

    localparam int KEEP_DEPTH = DEFAULT_CAPACITY;
    localparam int LONG_HOLD_CYCLES = 300;

    // One expected result transaction.
    typedef struct {
        logic [POS_W-1:0]          entry_count;
        logic                      inserted;
        logic [POS_W-1:0]          insert_position;
        logic [TAG_W-1:0]          read_tag;
        logic signed [VALUE_W-1:0] read_value;
        logic                      read_valid;
    } keeper_outcome_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_stall;
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] new_value;
    logic [TAG_W-1:0]          new_tag;
    logic [POS_W-1:0]          read_position;
    logic                      result_valid;
    logic                      result_stall;
    logic [POS_W-1:0]          entry_count;
    logic                      inserted;
    logic [POS_W-1:0]          insert_position;
    logic [TAG_W-1:0]          read_tag;
    logic signed [VALUE_W-1:0] read_value;
    logic                      read_valid;

    // Behavioral copy of the sorted store.
    logic signed [VALUE_W-1:0] kept_values [KEEP_DEPTH];
    logic [TAG_W-1:0]          kept_tags [KEEP_DEPTH];
    int                        kept_count;

    keeper_outcome_t outcome_q[$];
    int              fail_count;
    bit              idling_on;
    bit              long_hold_req;

    sorted_smallest_k_keeper_unit #(
        .CAPACITY(KEEP_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .mode(mode),
        .new_value(new_value),
        .new_tag(new_tag),
        .read_position(read_position),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .entry_count(entry_count),
        .inserted(inserted),
        .insert_position(insert_position),
        .read_tag(read_tag),
        .read_value(read_value),
        .read_valid(read_valid)
    );

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Empty the behavioral store, as reset and clear do.
    function automatic void clear_kept_store();
        for (int i = 0; i < KEEP_DEPTH; i++)
        begin
            kept_values[i] = '0;
            kept_tags[i]   = '0;
        end
        kept_count = 0;
    endfunction

    // Apply one accepted item to the behavioral store and return its result.
    function automatic keeper_outcome_t predict_keeper_outcome(
        input mode_t                     op,
        input logic signed [VALUE_W-1:0] value,
        input logic [TAG_W-1:0]          tag,
        input logic [POS_W-1:0]          position
    );
        keeper_outcome_t res;
        int              place;
        bit              found;
        res = '{default: '0};
        case (op)
            MODE_INSERT:
            begin
                // Land before the first strictly greater value.
                place = kept_count;
                found = 1'b0;
                for (int i = 0; i < kept_count; i++)
                begin
                    if (!found && kept_values[i] > value)
                    begin
                        place = i;
                        found = 1'b1;
                    end
                end
                if (place < KEEP_DEPTH)
                begin
                    for (int i = KEEP_DEPTH - 1; i > place; i--)
                    begin
                        kept_values[i] = kept_values[i-1];
                        kept_tags[i]   = kept_tags[i-1];
                    end
                    kept_values[place] = value;
                    kept_tags[place]   = tag;
                    if (kept_count < KEEP_DEPTH)
                        kept_count++;
                    res.inserted        = 1'b1;
                    res.insert_position = place[POS_W-1:0];
                end
            end
            MODE_READ:
            begin
                if (position < KEEP_DEPTH)
                begin
                    res.read_tag   = kept_tags[position];
                    res.read_value = kept_values[position];
                    res.read_valid = (position < kept_count);
                end
            end
            MODE_CLEAR:
                clear_kept_store();
            default:
                ;
        endcase
        res.entry_count = kept_count[POS_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        keeper_outcome_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("entry_count", longint'(want.entry_count),
                            longint'(entry_count));
                check_field("inserted", longint'(want.inserted), longint'(inserted));
                check_field("insert_position", longint'(want.insert_position),
                            longint'(insert_position));
                check_field("read_tag", longint'(want.read_tag), longint'(read_tag));
                check_field("read_value", longint'(want.read_value),
                            longint'(read_value));
                check_field("read_valid", longint'(want.read_valid),
                            longint'(read_valid));
            end
        end
    end

    // Receiver stall: random bursts, and one long hold-off on request.
    initial
    begin : result_stall_gen
        int hold_len;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (idling_on && rst_n && $urandom_range(0, 5) == 0)
            begin
                hold_len = $urandom_range(1, 16);
                result_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Offer one item transaction, wait for acceptance, record its prediction.
    task automatic send_item(
        input mode_t                     op,
        input logic signed [VALUE_W-1:0] value,
        input logic [TAG_W-1:0]          tag,
        input logic [POS_W-1:0]          position
    );
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode          <= op;
        new_value     <= value;
        new_tag       <= tag;
        read_position <= position;
        item_valid    <= 1'b1;
        do @(posedge clk); while (item_stall);
        outcome_q.push_back(predict_keeper_outcome(op, value, tag, position));
    endtask

    // Random item: mostly inserts with a mix of wide, tied and extreme values.
    task automatic send_random_item(input int insert_pct);
        mode_t                     op;
        logic signed [VALUE_W-1:0] value;
        int                        pick;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
            op = MODE_INSERT;
        else if (pick < 96)
            op = MODE_READ;
        else if (pick < 98)
            op = MODE_CLEAR;
        else
            op = MODE_UNUSED;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: value = $urandom;
            5, 6, 7:       value = int'($urandom_range(0, 16)) - 8;
            8:             value = 32'sh7FFF_FFFF;
            default:       value = 32'sh8000_0000;
        endcase
        send_item(op, value, TAG_W'($urandom), POS_W'($urandom_range(0, 31)));
    endtask

    // Let every expected result arrive, then a few more cycles.
    task automatic drain_results();
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        while (outcome_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (outcome_q.size() != 0)
        begin
            $error("%0d expected results never arrived", outcome_q.size());
            fail_count++;
            outcome_q.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // Reads of an empty store and the unused mode.
    task automatic test_empty_store();
        send_item(MODE_READ, 0, '0, POS_W'(0));
        send_item(MODE_READ, 0, '0, POS_W'(24));
        send_item(MODE_READ, 0, '0, POS_W'(25));
        send_item(MODE_READ, -1, 16'hFFFF, POS_W'(31));
        send_item(MODE_UNUSED, 32'sh7FFF_FFFF, 16'hFFFF, POS_W'(31));
        drain_results();
    endtask

    // Extreme values, ties, reads around the count, and clear.
    task automatic test_directed_ops();
        send_item(MODE_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, '0);
        send_item(MODE_INSERT, 32'sh8000_0000, 16'h0000, '0);
        send_item(MODE_INSERT, 0, 16'h1111, '0);
        send_item(MODE_INSERT, 0, 16'h2222, '0);
        send_item(MODE_INSERT, -1, 16'h3333, '0);
        send_item(MODE_INSERT, 32'sh7FFF_FFFF, 16'h4444, '0);
        for (int p = 0; p < 7; p++)
            send_item(MODE_READ, 0, '0, p[POS_W-1:0]);
        send_item(MODE_READ, 0, '0, POS_W'(24));
        send_item(MODE_UNUSED, 5, 16'h5555, POS_W'(2));
        send_item(MODE_CLEAR, 0, '0, '0);
        send_item(MODE_READ, 0, '0, '0);
        send_item(MODE_READ, 0, '0, POS_W'(3));
        drain_results();
    endtask

    // Episodes that each start from a clear, followed by random items that are mostly inserts.
    task automatic test_random_episodes();
        int length;
        for (int ep = 0; ep < 9; ep++)
        begin
            idling_on = ($urandom_range(0, 3) != 0);
            send_item(MODE_CLEAR, $urandom, TAG_W'($urandom),
                      POS_W'($urandom_range(0, 31)));
            length = $urandom_range(30, 70);
            for (int n = 0; n < length; n++)
                send_random_item(70);
        end
        drain_results();
    endtask

    // The receiver holds off while the sender keeps offering items.
    task automatic test_result_backpressure();
        idling_on = 1'b0;
        long_hold_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_random_item(75);
        drain_results();
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_quiet_tail();
        idling_on = 1'b0;
        for (int n = 0; n < 50; n++)
            send_random_item(65);
        drain_results();
    endtask

    // Main sequence.
    initial
    begin
        fail_count    = 0;
        idling_on     = 1'b1;
        long_hold_req = 1'b0;
        clear_kept_store();
        rst_n         <= 1'b0;
        item_valid    <= 1'b0;
        mode          <= MODE_INSERT;
        new_value     <= '0;
        new_tag       <= '0;
        read_position <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_directed_ops();
        test_random_episodes();
        test_result_backpressure();
        test_quiet_tail();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
